@@ rtl/ttg_pkg.sv @@
// ----------------------------------------------------------------------------
// ttg_pkg: shared types and constants of the timed tone generator
// widths, codes, seed values and the divider request and response records
// ----------------------------------------------------------------------------
package ttg_pkg;

    // input word layout
    localparam int FREQ_W   = 15;
    localparam int LEN_W    = 8;
    localparam int IN_DW    = 24;
    localparam int OUT_DW   = 16;

    // counters and divider
    localparam int CNT20_W  = 20;
    localparam int QUO_W    = CNT20_W;
    localparam int DVSR_W   = FREQ_W;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [QUO_W-1:0] DUR_NUM  = QUO_W'(1000000);
    localparam logic [QUO_W-1:0] HALF_NUM = QUO_W'(500000);

    // led patterns
    localparam int RISE_W = 9;
    localparam int FALL_W = 8;
    localparam int LED_W  = 10;
    localparam logic [RISE_W-1:0] RISE_INIT = 9'h001;
    localparam logic [RISE_W-1:0] RISE_LAST = 9'h080;
    localparam logic [FALL_W-1:0] FALL_INIT = 8'h80;
    localparam logic [7:0]        RND_MASK  = 8'ha4;

    // random source
    localparam int RNG_WORDS = 5;
    localparam logic [31:0] RNG_SEED [RNG_WORDS] = '{32'd666, 32'd1024, 32'd1337,
                                                     32'd999, 32'd4};

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_RNG      = 5'b00010,
        ST_DIV_DUR  = 5'b00100,
        ST_DIV_HALF = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [QUO_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/ttg_div.sv @@
// ----------------------------------------------------------------------------
// ttg_div: shared restoring divider
// two quotient bits per cycle, result valid with a one-cycle done pulse
// ----------------------------------------------------------------------------
module ttg_div
    import ttg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DVSR_W-1:0]    dvsr_reg, dvsr_next;

    logic [DVSR_W:0]   trial_a, trial_b, diff_a, diff_b;
    logic              bit_a, bit_b;
    logic [DVSR_W-1:0] rem_a, rem_b;

    always_comb
    begin
        // first quotient bit of the step
        trial_a = {rem_reg, quo_reg[QUO_W-1]};
        diff_a  = trial_a - {1'b0, dvsr_reg};
        bit_a   = (trial_a >= {1'b0, dvsr_reg});
        rem_a   = bit_a ? diff_a[DVSR_W-1:0] : trial_a[DVSR_W-1:0];
        // second quotient bit
        trial_b = {rem_a, quo_reg[QUO_W-2]};
        diff_b  = trial_b - {1'b0, dvsr_reg};
        bit_b   = (trial_b >= {1'b0, dvsr_reg});
        rem_b   = bit_b ? diff_b[DVSR_W-1:0] : trial_b[DVSR_W-1:0];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_b;
            quo_next = {quo_reg[QUO_W-3:0], bit_a, bit_b};
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/timed_tone_generator.sv @@
// ----------------------------------------------------------------------------
// timed_tone_generator: square-wave tone player with led patterns
// start words load a note, tick words advance it by one microsecond
// ----------------------------------------------------------------------------
// Every accepted input word yields exactly one output word. A tick word
// (tuser = 1) and a start word that arrives while a note is playing are
// handled at once in the idle state. A start word for a new note runs
// the sequencer: it steps the five-word xorshift source for the led term
// and its enable, then the shared two-bits-per-cycle divider works out
// 1000000/note_len and 500000/tone_freq (the second is skipped for a rest
// with tone_freq = 0), and a finish step updates the led patterns and
// posts the result. The input side is not ready while a start is in
// progress. The output word sits in a register, so the next input word is
// taken in the same cycle the current output word is taken. Once playing,
// every tick counts the duration and half-wave counters; the speaker flips
// at the half-wave count and on the last tick the speaker and the note's
// led bits are cleared and done_res is set. A note_len of zero plays as one.
// ----------------------------------------------------------------------------
module timed_tone_generator
    import ttg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // tone_freq[14:0], note_len[22:15], zero pad
    input  logic              s_axis_tuser,   // op: start or tick
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata    // speaker, led_port[10:1], busy_res, done_res, pad
);

    // sequencer
    state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;

    // operands latched at start
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    // random source and the masked random term
    logic [31:0] rng_reg [RNG_WORDS];
    logic [31:0] rng_next [RNG_WORDS];
    logic [7:0]  rnd_reg, rnd_next;

    // note state
    logic [RISE_W-1:0]  rise_reg, rise_next;
    logic [FALL_W-1:0]  fall_reg, fall_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic [CNT20_W-1:0] tick_reg, tick_next;
    logic [CNT20_W-1:0] dur_reg, dur_next;
    logic [CNT20_W-1:0] wave_reg, wave_next;
    logic [CNT20_W-1:0] half_reg, half_next;
    logic               spk_reg, spk_next;
    logic               play_reg, play_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [OUT_DW-1:0] m_data_reg, m_data_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // combinational helpers
    logic               in_acc;
    logic [FREQ_W-1:0]  in_freq;
    logic [LEN_W-1:0]   in_len;
    logic [31:0]        xs_t, xs_v;
    logic [7:0]         xs_odd;
    logic [15:0]        xs_prod;
    logic [CNT20_W-1:0] tick_inc, wave_inc;
    logic [LED_W-1:0]   led_sum;
    logic               load_out;
    logic               done_flag;

    ttg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        in_acc  = s_axis_tvalid && s_axis_tready;
        in_freq = s_axis_tdata[FREQ_W-1:0];
        in_len  = s_axis_tdata[FREQ_W +: LEN_W];

        // one xorshift step; only the low byte of the product is ever used
        xs_t    = rng_reg[0] ^ (rng_reg[0] >> 7);
        xs_v    = (rng_reg[4] ^ (rng_reg[4] << 6)) ^ (xs_t ^ (xs_t << 13));
        xs_odd  = {rng_reg[2][6:0], 1'b1};
        xs_prod = xs_odd * xs_v[7:0];

        tick_inc = tick_reg + 1'b1;
        wave_inc = wave_reg + 1'b1;
        led_sum  = '0;

        state_next = state_reg;
        step_next  = step_reg;
        freq_next  = freq_reg;
        len_next   = len_reg;
        rng_next   = rng_reg;
        rnd_next   = rnd_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        led_next   = led_reg;
        tick_next  = tick_reg;
        dur_next   = dur_reg;
        wave_next  = wave_reg;
        half_next  = half_reg;
        spk_next   = spk_reg;
        play_next  = play_reg;
        load_out   = 1'b0;
        done_flag  = 1'b0;

        div_req.start    = 1'b0;
        div_req.dividend = DUR_NUM;
        div_req.divisor  = {{(DVSR_W - LEN_W){1'b0}}, len_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if ((s_axis_tuser == OP_START) && !play_reg)
                    begin
                        freq_next  = in_freq;
                        len_next   = (in_len == '0) ? LEN_W'(1) : in_len;
                        step_next  = '0;
                        state_next = ST_RNG;
                    end
                    else
                    begin
                        if ((s_axis_tuser == OP_TICK) && play_reg)
                        begin
                            tick_next = tick_inc;
                            wave_next = wave_inc;
                            if ((half_reg != '0) && (wave_inc >= half_reg))
                            begin
                                spk_next  = ~spk_reg;
                                wave_next = '0;
                            end
                            if (tick_inc >= dur_reg)
                            begin
                                led_sum   = {1'b0, rise_reg} + {2'b00, fall_reg};
                                led_next  = led_reg & ~led_sum;
                                spk_next  = 1'b0;
                                play_next = 1'b0;
                                done_flag = 1'b1;
                            end
                        end
                        load_out = 1'b1;
                    end
                end
            end

            ST_RNG:
            begin
                // step 0 is discarded, step 1 gives the led term, step 2 its enable
                rng_next[0] = rng_reg[1];
                rng_next[1] = rng_reg[2];
                rng_next[2] = rng_reg[3];
                rng_next[3] = rng_reg[4];
                rng_next[4] = xs_v;
                step_next   = step_reg + 1'b1;
                if (step_reg == 2'd1)
                begin
                    rnd_next = xs_prod[7:0] & RND_MASK;
                end
                if (step_reg == 2'd2)
                begin
                    rnd_next      = xs_prod[0] ? rnd_reg : 8'h00;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_DUR;
                end
            end

            ST_DIV_DUR:
            begin
                div_req.dividend = HALF_NUM;
                div_req.divisor  = freq_reg;
                if (div_rsp.done)
                begin
                    dur_next = div_rsp.quotient;
                    if (freq_reg == '0)
                    begin
                        half_next  = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV_HALF;
                    end
                end
            end

            ST_DIV_HALF:
            begin
                if (div_rsp.done)
                begin
                    half_next  = div_rsp.quotient;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                rise_next = (rise_reg <= RISE_LAST) ? (rise_reg << 1) : RISE_INIT;
                fall_next = (fall_reg != '0) ? (fall_reg >> 1) : FALL_INIT;
                led_sum   = {1'b0, rise_next} + {2'b00, fall_next} + {2'b00, rnd_reg};
                led_next  = led_reg | led_sum;
                tick_next = '0;
                wave_next = '0;
                play_next = 1'b1;
                load_out  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output word register
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, done_flag, play_next, led_next, spk_next};
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            rng_reg     <= RNG_SEED;
            rise_reg    <= RISE_INIT;
            fall_reg    <= FALL_INIT;
            led_reg     <= '0;
            tick_reg    <= '0;
            dur_reg     <= '0;
            wave_reg    <= '0;
            half_reg    <= '0;
            spk_reg     <= 1'b0;
            play_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            rng_reg     <= rng_next;
            rise_reg    <= rise_next;
            fall_reg    <= fall_next;
            led_reg     <= led_next;
            tick_reg    <= tick_next;
            dur_reg     <= dur_next;
            wave_reg    <= wave_next;
            half_reg    <= half_next;
            spk_reg     <= spk_next;
            play_reg    <= play_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg   <= freq_next;
        len_reg    <= len_next;
        rnd_reg    <= rnd_next;
        m_data_reg <= m_data_next;
    end

endmodule

@@ bench/timed_tone_generator_tb.sv @@
// ----------------------------------------------------------------------------
// timed_tone_generator_tb: self-checking bench for the timed tone generator
// start and tick words go in over the input stream, and every status word
// coming back is compared field by field against a cycle-free software copy
// of the tone player (xorshift source, led patterns, counters, speaker)
// ----------------------------------------------------------------------------
module timed_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttg_pkg::*;

    // watchdog bound on the run length, set with room for heavy stalls
    localparam int CYCLE_LIMIT = 100_000;

    // one status word as the block reports it
    typedef struct packed {
        logic       speaker;
        logic [9:0] led_port;
        logic       busy;
        logic       done;
    } tone_status_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata  = '0;    // tone_freq[14:0], note_len[22:15], pad
    logic              s_axis_tuser  = 1'b0;  // op
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;          // speaker, led_port[10:1], busy[11], done[12]

    // software copy of the player state
    logic [31:0] xs_word [5];
    logic [8:0]  rise_pat;
    logic [7:0]  fall_pat;
    logic [9:0]  led_q;
    logic [19:0] tick_q;
    logic [19:0] dur_q;
    logic [19:0] wave_q;
    logic [19:0] half_q;
    logic        spk_q;
    logic        playing_q;

    // status words still owed by the block, oldest first
    tone_status_t pending_status [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    timed_tone_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 50 MHz clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // player copy
    // ------------------------------------------------------------------------

    function automatic void player_reset();
        // xorshift seed words
        xs_word[0] = 32'd666;
        xs_word[1] = 32'd1024;
        xs_word[2] = 32'd1337;
        xs_word[3] = 32'd999;
        xs_word[4] = 32'd4;
        rise_pat   = 9'h001;
        fall_pat   = 8'h80;
        led_q      = '0;
        tick_q     = '0;
        dur_q      = '0;
        wave_q     = '0;
        half_q     = '0;
        spk_q      = 1'b0;
        playing_q  = 1'b0;
    endfunction

    // five-word xorshift with the odd-multiplier output scramble
    function automatic logic [31:0] xorshift_next();
        logic [31:0] t;
        logic [31:0] v;
        t          = xs_word[0] ^ (xs_word[0] >> 7);
        v          = xs_word[4];
        xs_word[0] = xs_word[1];
        xs_word[1] = xs_word[2];
        xs_word[2] = xs_word[3];
        xs_word[3] = v;
        v          = (v ^ (v << 6)) ^ (t ^ (t << 13));
        xs_word[4] = v;
        return (xs_word[1] + xs_word[1] + 32'd1) * v;
    endfunction

    // apply one input word and return the status the block should report
    function automatic tone_status_t advance_tone(input logic op, input logic [14:0] freq,
                                                  input logic [7:0] len);
        logic [7:0]   len_eff;
        logic [31:0]  r1;
        logic [31:0]  r2;
        logic [31:0]  sum;
        tone_status_t st;
        st.done = 1'b0;
        if (op == OP_START)
        begin
            // a start during a note is dropped
            if (!playing_q)
            begin
                void'(xorshift_next());
                len_eff = (len == 8'd0) ? 8'd1 : len;
                dur_q   = 20'(32'd1000000 / {24'd0, len_eff});
                // rest: no half-wave count, speaker stays put
                half_q  = (freq == '0) ? 20'd0 : 20'(32'd500000 / {17'd0, freq});
                tick_q  = '0;
                wave_q  = '0;
                if (rise_pat <= 9'h080)
                    rise_pat = rise_pat << 1;
                else
                    rise_pat = 9'h001;
                if (fall_pat >= 8'h01)
                    fall_pat = fall_pat >> 1;
                else
                    fall_pat = 8'h80;
                // left draw first, then the enable bit
                r1        = xorshift_next() & 32'h0000_00a4;
                r2        = xorshift_next() & 32'h0000_0001;
                sum       = 32'(rise_pat) + 32'(fall_pat) + r1 * r2;
                led_q     = led_q | sum[9:0];
                playing_q = 1'b1;
            end
        end
        else if (playing_q)
        begin
            tick_q = tick_q + 20'd1;
            wave_q = wave_q + 20'd1;
            if (half_q != '0 && wave_q >= half_q)
            begin
                spk_q  = ~spk_q;
                wave_q = '0;
            end
            // last tick: toggle above may happen first, then speaker forced low
            if (tick_q >= dur_q)
            begin
                led_q     = led_q & ~(10'(rise_pat) + 10'(fall_pat));
                spk_q     = 1'b0;
                playing_q = 1'b0;
                st.done   = 1'b1;
            end
        end
        st.speaker  = spk_q;
        st.led_port = led_q;
        st.busy     = playing_q;
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one word, hold it until taken, then record what it should produce
    task automatic push_word(input logic op, input logic [14:0] freq, input logic [7:0] len);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, len, freq};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_status.push_back(advance_tone(op, freq, len));
    endtask

    // tick with random don't-care fields
    task automatic push_tick();
        push_word(OP_TICK, 15'($urandom), 8'($urandom));
    endtask

    // stop sending until every owed status word is back
    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    // receiver back-pressure, decided every cycle
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic field_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
        fail_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // compare every taken status word with the oldest one owed
    initial
    begin
        tone_status_t want;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_status.size() == 0)
                begin
                    fail_count++;
                    $error("status word 0x%h with none owed", m_axis_tdata);
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (m_axis_tdata[0] !== want.speaker)
                        field_mismatch("speaker", want.speaker, m_axis_tdata[0]);
                    if (m_axis_tdata[10:1] !== want.led_port)
                        field_mismatch("led_port", want.led_port, m_axis_tdata[10:1]);
                    if (m_axis_tdata[11] !== want.busy)
                        field_mismatch("busy_res", want.busy, m_axis_tdata[11]);
                    if (m_axis_tdata[12] !== want.done)
                        field_mismatch("done_res", want.done, m_axis_tdata[12]);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed_tone_generator: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // ticks before any note do nothing, whatever their fields hold
    task automatic test_idle_ticks();
        push_word(OP_TICK, 15'h7fff, 8'hff);
        push_word(OP_TICK, 15'h0000, 8'h00);
        push_tick();
    endtask

    // 20 kHz note with a 25-tick half wave; note_len zero plays as one, so the
    // note outlasts the whole run and the speaker flips many times
    task automatic test_start_note();
        push_word(OP_START, 15'd20000, 8'h00);
    endtask

    // starts with extreme fields while a note plays are dropped
    task automatic test_busy_starts();
        push_word(OP_START, 15'h7fff, 8'hff);
        push_tick();
        push_word(OP_START, 15'h0000, 8'h00);
        push_tick();
        push_word(OP_START, 15'h0001, 8'h01);
        push_tick();
    endtask

    // ticks of the playing note, with a few stray starts mixed in
    task automatic test_note_ticks(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 4)
                push_word(OP_START, 15'($urandom), 8'($urandom));
            else
                push_tick();
        end
    endtask

    initial
    begin
        player_reset();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // light sender gaps, heavy receiver stalls
        src_idle_pct  = 14;
        sink_idle_pct = 83;
        test_idle_ticks();
        test_start_note();
        test_note_ticks(180);
        wait_drain();

        // heavy sender gaps, light receiver stalls
        src_idle_pct  = 83;
        sink_idle_pct = 14;
        test_busy_starts();
        test_note_ticks(180);

        // full rate both ways
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_note_ticks(180);

        wait_drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("timed_tone_generator: match");
        else
            $display("timed_tone_generator: mismatch");
        $finish;
    end

endmodule
